[rtl/lpfs_pkg.sv]
package lpfs_pkg;

  localparam int MAX_PIXELS = 256;
  localparam int PIX_AW = $clog2(MAX_PIXELS);
  localparam int LEN_W = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd140;
  localparam int COLOR_W = 24;
  localparam int BYTES_PER_PIXEL = 9;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BYTES_PER_PIXEL - 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } lpfs_op_t;

  typedef enum logic {
    ST_EXEC,
    ST_READ
  } lpfs_state_t;

  typedef struct packed {
    lpfs_op_t                 op;
    logic [PIX_AW-1:0]        idx;
    logic [COLOR_W-1:0]       color;
  } lpfs_item_t;

  // one byte of the 72-bit symbol stream, each color bit becomes 1 b 0
  function automatic logic [7:0] symbol_byte(logic [COLOR_W-1:0] color,
                                             logic [POS_W-1:0] k);
    logic [3*COLOR_W-1:0] s;
    logic [7:0] r;
    for (int i = 0; i < COLOR_W; i++) begin
      s[3*COLOR_W-1-3*i] = 1'b1;
      s[3*COLOR_W-2-3*i] = color[COLOR_W-1-i];
      s[3*COLOR_W-3-3*i] = 1'b0;
    end
    case (k)
      4'd0: r = s[71:64];
      4'd1: r = s[63:56];
      4'd2: r = s[55:48];
      4'd3: r = s[47:40];
      4'd4: r = s[39:32];
      4'd5: r = s[31:24];
      4'd6: r = s[23:16];
      4'd7: r = s[15:8];
      default: r = s[7:0];
    endcase
    return r;
  endfunction

endpackage

[rtl/lpfs_front.sv]
module lpfs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                action,
  input  logic [7:0]                pixel_index,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  input  logic [lpfs_pkg::LEN_W-1:0] eff_len,
  output logic                      q_valid,
  output lpfs_pkg::lpfs_item_t      q_item,
  input  logic                      q_pop
);
  import lpfs_pkg::*;

  lpfs_item_t             queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_AW:0]      count;
  logic                   full;
  logic                   accept;
  logic                   keep;
  logic                   push;
  lpfs_item_t             item;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    item.op    = lpfs_op_t'(action);
    item.idx   = pixel_index;
    item.color = {green, red, blue};
    // writes past the strip end are dropped here
    keep = !((item.op == OP_WRITE) && ({1'b0, pixel_index} >= eff_len));
  end

  assign push    = accept && keep;
  assign q_valid = (count != '0);
  assign q_item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/lpfs_back.sv]
module lpfs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lpfs_pkg::LEN_W-1:0] eff_len,
  input  logic                      q_valid,
  input  lpfs_pkg::lpfs_item_t      q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                spi_byte,
  output logic                      frame_end
);
  import lpfs_pkg::*;

  logic [COLOR_W-1:0]     mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0]  written;
  logic [COLOR_W-1:0]     rd_data;
  logic                   rd_hit;

  lpfs_state_t            state;
  lpfs_state_t            state_next;
  logic                   sending;
  logic [PIX_AW-1:0]      pixel_pointer;
  logic [POS_W-1:0]       byte_position;

  logic                   mem_we;
  logic                   do_clear;
  logic                   do_start;
  logic                   rd_en;
  logic                   emit;
  logic                   slot_free;

  logic [POS_W-1:0]       k;
  logic                   last_byte;
  logic                   last_pixel;
  logic [COLOR_W-1:0]     pixel;

  assign slot_free  = !out_valid || !out_stall;
  assign k          = (byte_position > LAST_POS) ? LAST_POS : byte_position;
  assign last_byte  = (k == LAST_POS);
  assign last_pixel = (({1'b0, pixel_pointer} + LEN_W'(1)) >= eff_len);
  assign pixel      = rd_hit ? rd_data : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EXEC: begin
        if (q_valid && (q_item.op == OP_TICK) && sending) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          state_next = ST_EXEC;
        end
      end
      default: state_next = ST_EXEC;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    do_clear = 1'b0;
    do_start = 1'b0;
    rd_en    = 1'b0;
    emit     = 1'b0;
    unique case (state)
      ST_EXEC: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_WRITE: mem_we   = 1'b1;
            OP_CLEAR: do_clear = 1'b1;
            OP_START: do_start = !sending && (eff_len != '0);
            OP_TICK:  rd_en    = sending;
            default:  ;
          endcase
        end
      end
      ST_READ: emit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.idx] <= q_item.color;
    end
    if (rd_en) begin
      rd_data <= mem[pixel_pointer];
      rd_hit  <= written[pixel_pointer];
    end
    if (emit) begin
      spi_byte  <= symbol_byte(pixel, k);
      frame_end <= last_byte && last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_EXEC;
      written       <= '0;
      sending       <= 1'b0;
      pixel_pointer <= '0;
      byte_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // entries never written since the last clear read as black
      if (do_clear) begin
        written <= '0;
      end else if (mem_we) begin
        written[q_item.idx] <= 1'b1;
      end
      if (do_start) begin
        sending       <= 1'b1;
        pixel_pointer <= '0;
        byte_position <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        if (last_byte) begin
          byte_position <= '0;
          if (last_pixel) begin
            sending       <= 1'b0;
            pixel_pointer <= '0;
          end else begin
            pixel_pointer <= pixel_pointer + 1'b1;
          end
        end else begin
          byte_position <= k + 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/led_pixel_frame_serializer_unit.sv]
// LED pixel frame serializer: items enter a four-entry queue and are executed in order by a
// back end that owns the 256 x 24-bit pixel memory. A write, a clear or a frame start is
// executed as the back end pops it (a clear drops every entry to black at once); a tick
// during a frame goes through the registered memory read, then the encoding of the symbol
// byte into the output register, and no further item is popped until that byte is encoded.
// A stalled output holds the back end at that step while the queue keeps taking items until
// it fills. No pass runs after reset; the block takes items from the first cycle after reset.
module led_pixel_frame_serializer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] pixel_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] spi_byte,
  output logic       frame_end,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);
  import lpfs_pkg::*;

  logic [LEN_W-1:0] strip_length;
  logic [LEN_W-1:0] eff_len;
  logic             q_valid;
  lpfs_item_t       q_item;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length <= LEN_RESET;
    end else if (cfg_we) begin
      strip_length <= cfg_wdata;
    end
  end

  assign eff_len = (strip_length > LEN_W'(MAX_PIXELS)) ? LEN_W'(MAX_PIXELS) : strip_length;

  lpfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .eff_len     (eff_len),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lpfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_len   (eff_len),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .spi_byte  (spi_byte),
    .frame_end (frame_end)
  );

endmodule
